// ----- sv/ffa_pkg.sv -----
package ffa_pkg;

    localparam int FFA_ARENA_WORDS = 4096;

    localparam int CFG_W  = 15;
    localparam int KIND_W = 2;
    localparam int SIZE_W = 15;
    localparam int OFF_W  = 12;
    localparam int ST_W   = 2;
    // ceil(size_bytes / 4) for any 15-bit byte count
    localparam int NEED_W = SIZE_W - 1;

    localparam logic [CFG_W-1:0] ARENA_BYTES_RST = 15'd16384;
    localparam int MIN_SPAN = 2;

    localparam logic [KIND_W-1:0] KIND_ALLOC   = 2'd0;
    localparam logic [KIND_W-1:0] KIND_FREE    = 2'd1;
    localparam logic [KIND_W-1:0] KIND_REALLOC = 2'd2;

    localparam logic [ST_W-1:0] ST_OK        = 2'd0;
    localparam logic [ST_W-1:0] ST_OOM       = 2'd1;
    localparam logic [ST_W-1:0] ST_NOT_ALLOC = 2'd2;

    typedef logic [3:0] upc_t;

    localparam upc_t S_IDLE     = 4'd0;
    localparam upc_t S_CHK      = 4'd1;
    localparam upc_t S_CHK_WAIT = 4'd2;
    localparam upc_t S_CHK_KIND = 4'd3;
    localparam upc_t S_WALK     = 4'd4;
    localparam upc_t S_WALK_RD  = 4'd5;
    localparam upc_t S_WALK_LAT = 4'd6;
    localparam upc_t S_WALK_FIT = 4'd7;
    localparam upc_t S_WALK_ADV = 4'd8;
    localparam upc_t S_TAKE     = 4'd9;
    localparam upc_t S_SPLIT    = 4'd10;
    localparam upc_t S_FREE_WR  = 4'd11;
    localparam upc_t S_OOM      = 4'd12;
    localparam upc_t S_NA       = 4'd13;
    localparam upc_t S_DONE     = 4'd14;
    localparam upc_t S_RET      = 4'd15;

    typedef enum logic [3:0] {
        U_NOP,
        U_LOAD,
        U_RD_OLD,
        U_LATCH_OLD,
        U_INIT_H,
        U_RD_H,
        U_LATCH_E,
        U_ADV_H,
        U_TAKE,
        U_SPLIT,
        U_WR_FREE,
        U_SET_OOM,
        U_SET_NA,
        U_EMIT
    } uop_t;

    typedef enum logic [3:0] {
        C_NONE,
        C_ALWAYS,
        C_DISPATCH,
        C_OFF_BAD,
        C_NOT_HELD,
        C_KIND_FREE,
        C_KIND_ALLOC,
        C_AT_END,
        C_FIT,
        C_OUT_BUSY
    } cond_t;

    typedef struct packed {
        uop_t  op;
        cond_t cond;
        upc_t  target;
    } uword_t;

    typedef struct packed {
        logic              fire;
        logic [KIND_W-1:0] kind;
        logic              off_bad;
        logic              not_held;
        logic              kind_free;
        logic              kind_alloc;
        logic              at_end;
        logic              fit;
        logic              out_busy;
    } flags_t;

    // Control store. Cond true: go to target, else next; dispatch: kind/stay.
    function automatic uword_t ucode(input upc_t pc);
        uword_t w;
        unique case (pc)
            S_IDLE:     w = '{op: U_LOAD,      cond: C_DISPATCH,   target: S_IDLE};
            S_CHK:      w = '{op: U_RD_OLD,    cond: C_OFF_BAD,    target: S_NA};
            S_CHK_WAIT: w = '{op: U_LATCH_OLD, cond: C_NOT_HELD,   target: S_NA};
            S_CHK_KIND: w = '{op: U_NOP,       cond: C_KIND_FREE,  target: S_FREE_WR};
            S_WALK:     w = '{op: U_INIT_H,    cond: C_NONE,       target: S_IDLE};
            S_WALK_RD:  w = '{op: U_RD_H,      cond: C_AT_END,     target: S_OOM};
            S_WALK_LAT: w = '{op: U_LATCH_E,   cond: C_NONE,       target: S_IDLE};
            S_WALK_FIT: w = '{op: U_NOP,       cond: C_FIT,        target: S_TAKE};
            S_WALK_ADV: w = '{op: U_ADV_H,     cond: C_ALWAYS,     target: S_WALK_RD};
            S_TAKE:     w = '{op: U_TAKE,      cond: C_NONE,       target: S_IDLE};
            S_SPLIT:    w = '{op: U_SPLIT,     cond: C_KIND_ALLOC, target: S_DONE};
            S_FREE_WR:  w = '{op: U_WR_FREE,   cond: C_ALWAYS,     target: S_DONE};
            S_OOM:      w = '{op: U_SET_OOM,   cond: C_ALWAYS,     target: S_DONE};
            S_NA:       w = '{op: U_SET_NA,    cond: C_ALWAYS,     target: S_DONE};
            S_DONE:     w = '{op: U_EMIT,      cond: C_OUT_BUSY,   target: S_DONE};
            S_RET:      w = '{op: U_NOP,       cond: C_ALWAYS,     target: S_IDLE};
            default:    w = '{op: U_NOP,       cond: C_ALWAYS,     target: S_IDLE};
        endcase
        return w;
    endfunction

    function automatic upc_t dispatch(input logic [KIND_W-1:0] kind);
        upc_t pc;
        unique case (kind) inside
            KIND_ALLOC:              pc = S_WALK;
            KIND_FREE, KIND_REALLOC: pc = S_CHK;
            default:                 pc = S_DONE;
        endcase
        return pc;
    endfunction

    // Arena size in words, clamped to [MIN_SPAN, words].
    function automatic int clamp_span(input logic [CFG_W-1:0] bytes, input int words);
        int w;
        w = int'(bytes[CFG_W-1:2]);
        if (w < MIN_SPAN)
            w = MIN_SPAN;
        if (w > words)
            w = words;
        return w;
    endfunction

endpackage

// ----- sv/ffa_req_if.sv -----
interface ffa_req_if;
    import ffa_pkg::*;

    logic              valid;
    logic              ready;
    logic [KIND_W-1:0] kind;
    logic [SIZE_W-1:0] size_bytes;
    logic [OFF_W-1:0]  block_offset;

    modport source (output valid, kind, size_bytes, block_offset, input ready);
    modport sink   (input valid, kind, size_bytes, block_offset, output ready);
endinterface

// ----- sv/ffa_rsp_if.sv -----
interface ffa_rsp_if;
    import ffa_pkg::*;

    logic             valid;
    logic             ready;
    logic [OFF_W-1:0] result_offset;
    logic [ST_W-1:0]  status;

    modport source (output valid, result_offset, status, input ready);
    modport sink   (input valid, result_offset, status, output ready);
endinterface

// ----- sv/ffa_ram.sv -----
module ffa_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

// ----- sv/ffa_useq.sv -----
module ffa_useq (
    input  logic            clk,
    input  logic            rst_n,
    input  ffa_pkg::flags_t flags,
    output ffa_pkg::uop_t   op
);
    import ffa_pkg::*;

    upc_t   upc_reg;
    upc_t   upc_next;
    uword_t uw;
    logic   take;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            upc_reg <= S_IDLE;
        end
        else
        begin
            upc_reg <= upc_next;
        end
    end

    always_comb
    begin
        uw = ucode(upc_reg);
        op = uw.op;
        unique case (uw.cond)
            C_NONE:       take = 1'b0;
            C_ALWAYS:     take = 1'b1;
            C_DISPATCH:   take = flags.fire;
            C_OFF_BAD:    take = flags.off_bad;
            C_NOT_HELD:   take = flags.not_held;
            C_KIND_FREE:  take = flags.kind_free;
            C_KIND_ALLOC: take = flags.kind_alloc;
            C_AT_END:     take = flags.at_end;
            C_FIT:        take = flags.fit;
            C_OUT_BUSY:   take = flags.out_busy;
            default:      take = 1'b0;
        endcase

        if (uw.cond == C_DISPATCH)
        begin
            upc_next = take ? dispatch(flags.kind) : upc_reg;
        end
        else if (take)
        begin
            upc_next = uw.target;
        end
        else
        begin
            upc_next = upc_reg + upc_t'(1);
        end
    end
endmodule

// ----- sv/ffa_dp.sv -----
module ffa_dp #(
    parameter int ARENA_WORDS = ffa_pkg::FFA_ARENA_WORDS
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  ffa_pkg::uop_t              op,
    output ffa_pkg::flags_t            flags,
    ffa_req_if.sink                    req,
    ffa_rsp_if.source                  rsp,
    input  logic                       cfg_we,
    input  logic [ffa_pkg::CFG_W-1:0]  cfg_wdata
);
    import ffa_pkg::*;

    localparam int IW  = $clog2(ARENA_WORDS);
    localparam int HW  = IW + 1;             // mark + size
    localparam int SPW = IW + 1;
    localparam int PW  = IW + 2;             // walk position can overshoot the end
    localparam int CW  = ((PW > NEED_W) ? PW : NEED_W) + 1;
    localparam int RST_SPAN = clamp_span(ARENA_BYTES_RST, ARENA_WORDS);

    logic [SPW-1:0]    span_reg;
    logic [HW-1:0]     hdr0_reg;            // header 0 lives outside the RAM
    logic              out_valid_reg;
    logic [OFF_W-1:0]  out_off_reg;
    logic [ST_W-1:0]   out_st_reg;

    logic [KIND_W-1:0] kind_reg;
    logic [NEED_W-1:0] need_reg;
    logic [OFF_W-1:0]  off_reg;
    logic [IW-1:0]     old_reg;
    logic [IW-1:0]     old_size_reg;
    logic [PW-1:0]     h_reg;
    logic [HW-1:0]     e_reg;
    logic              rd_zero_reg;
    logic [OFF_W-1:0]  res_reg;
    logic [ST_W-1:0]   st_reg;

    logic              fire;
    logic              out_busy;
    logic [HW-1:0]     rd_hdr;
    logic [CW-1:0]     h_c;
    logic [CW-1:0]     need_c;
    logic [CW-1:0]     span_c;
    logic [CW-1:0]     w_c;
    logic [CW-1:0]     old_c;
    logic [CW-1:0]     data_end;
    logic [CW-1:0]     blk_end;
    logic [CW-1:0]     split_c;
    logic [CW-1:0]     adv_c;
    logic              fit;
    logic              split_ok;
    logic [SPW-1:0]    cfg_span;
    logic [HW-1:0]     cfg_hdr;

    logic              wen;
    logic [IW-1:0]     waddr;
    logic [HW-1:0]     wdata;
    logic              ram_we;
    logic [IW-1:0]     raddr;
    logic [HW-1:0]     ram_rdata;

    ffa_ram #(
        .WIDTH (HW),
        .DEPTH (ARENA_WORDS)
    ) u_hdr_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (waddr),
        .wdata (wdata),
        .raddr (raddr),
        .rdata (ram_rdata)
    );

    always_comb
    begin
        fire      = (op == U_LOAD) && req.valid;
        req.ready = (op == U_LOAD);
        out_busy  = out_valid_reg && !rsp.ready;
        rd_hdr    = rd_zero_reg ? hdr0_reg : ram_rdata;

        h_c      = CW'(h_reg);
        need_c   = CW'(need_reg);
        span_c   = CW'(span_reg);
        w_c      = CW'(e_reg[IW-1:0]);
        old_c    = CW'(off_reg) - CW'(1);
        data_end = h_c + CW'(1);
        blk_end  = data_end + need_c;
        split_c  = w_c - need_c - CW'(1);
        adv_c    = data_end + w_c;

        fit      = !e_reg[HW-1] && (w_c >= need_c) && (data_end < span_c)
                   && (blk_end <= span_c);
        split_ok = (w_c > need_c) && (blk_end < span_c);

        cfg_span = SPW'(clamp_span(cfg_wdata, ARENA_WORDS));
        cfg_hdr  = {1'b0, cfg_span[IW-1:0] - IW'(1)};

        raddr = (op == U_RD_OLD) ? old_c[IW-1:0] : h_reg[IW-1:0];

        wen   = 1'b0;
        waddr = h_reg[IW-1:0];
        wdata = {1'b1, need_c[IW-1:0]};
        case (op)
            U_TAKE:
            begin
                wen = 1'b1;
            end
            U_SPLIT:
            begin
                wen   = split_ok;
                waddr = blk_end[IW-1:0];
                wdata = {1'b0, split_c[IW-1:0]};
            end
            U_WR_FREE:
            begin
                wen   = 1'b1;
                waddr = old_reg;
                wdata = {1'b0, old_size_reg};
            end
            default:
            begin
                wen = 1'b0;
            end
        endcase
        ram_we = wen && (waddr != '0);

        flags.fire       = fire;
        flags.kind       = req.kind;
        flags.off_bad    = (off_reg == '0) || (old_c >= span_c);
        flags.not_held   = !rd_hdr[HW-1];
        flags.kind_free  = (kind_reg == KIND_FREE);
        flags.kind_alloc = (kind_reg == KIND_ALLOC);
        flags.at_end     = (h_c >= span_c);
        flags.fit        = fit;
        flags.out_busy   = out_busy;

        rsp.valid         = out_valid_reg;
        rsp.result_offset = out_off_reg;
        rsp.status        = out_st_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            span_reg      <= SPW'(RST_SPAN);
            hdr0_reg      <= {1'b0, IW'(RST_SPAN - 1)};
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                span_reg <= cfg_span;
                hdr0_reg <= cfg_hdr;
            end
            else if (wen && (waddr == '0))
            begin
                hdr0_reg <= wdata;
            end

            if ((op == U_EMIT) && !out_busy)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        case (op)
            U_LOAD:
            begin
                if (fire)
                begin
                    kind_reg <= req.kind;
                    need_reg <= NEED_W'(req.size_bytes[SIZE_W-1:2])
                                + NEED_W'(|req.size_bytes[1:0]);
                    off_reg  <= req.block_offset;
                    res_reg  <= '0;
                    st_reg   <= ST_OK;
                end
            end
            U_RD_OLD:
            begin
                old_reg     <= raddr;
                rd_zero_reg <= (raddr == '0);
            end
            U_RD_H:
            begin
                rd_zero_reg <= (raddr == '0);
            end
            U_LATCH_OLD:
            begin
                old_size_reg <= rd_hdr[IW-1:0];
            end
            U_INIT_H:
            begin
                h_reg <= '0;
            end
            U_LATCH_E:
            begin
                e_reg <= rd_hdr;
            end
            U_ADV_H:
            begin
                h_reg <= adv_c[PW-1:0];
            end
            U_TAKE:
            begin
                res_reg <= data_end[OFF_W-1:0];
            end
            U_SET_OOM:
            begin
                st_reg <= ST_OOM;
            end
            U_SET_NA:
            begin
                st_reg <= ST_NOT_ALLOC;
            end
            U_EMIT:
            begin
                if (!out_busy)
                begin
                    out_off_reg <= res_reg;
                    out_st_reg  <= st_reg;
                end
            end
            default:
            begin
            end
        endcase
    end
endmodule

// ----- sv/first_fit_block_allocator.sv -----
// First-fit allocator over a word arena of up to ARENA_WORDS words. Each block
// starts with a one-word header (size in words plus an allocated mark); an
// allocate walks the headers from word 0, takes the first free block that is
// big enough, splits the leftover into a new free block and returns the data
// offset. Free clears the mark (status 2 for an unallocated block); realloc
// checks the old block, allocates a new one, then frees the old one. Writing
// cfg_wdata (arena size in bytes) rebuilds header 0 as one free block. Each
// request transaction yields one response transaction. Header 0 is held in a
// register, so no clearing pass is needed after reset. The walk reads one
// header from the header RAM per walk step. One request is in flight at a
// time; a request finishing while the previous response still waits stalls
// until that response is taken.
module first_fit_block_allocator #(
    parameter int ARENA_WORDS = ffa_pkg::FFA_ARENA_WORDS
) (
    input  logic                      clk,
    input  logic                      rst_n,
    ffa_req_if.sink                   req,
    ffa_rsp_if.source                 rsp,
    input  logic                      cfg_we,
    input  logic [ffa_pkg::CFG_W-1:0] cfg_wdata
);
    import ffa_pkg::*;

    flags_t flags;
    uop_t   op;

    ffa_useq u_useq (
        .clk   (clk),
        .rst_n (rst_n),
        .flags (flags),
        .op    (op)
    );

    ffa_dp #(
        .ARENA_WORDS (ARENA_WORDS)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .op        (op),
        .flags     (flags),
        .req       (req),
        .rsp       (rsp),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );
endmodule

// ----- sv/ffa_chk.sv -----
module ffa_chk (
    input logic                      clk,
    input logic                      rst_n,
    input logic                      req_valid,
    input logic                      req_ready,
    input logic                      rsp_valid,
    input logic                      rsp_ready,
    input logic [ffa_pkg::OFF_W-1:0] rsp_result_offset,
    input logic [ffa_pkg::ST_W-1:0]  rsp_status
);
    import ffa_pkg::*;

    // one request at a time: busy right after a transaction
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready |=> !req_ready)
        else $error("request accepted while previous one still in flight");

    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=>
            rsp_valid && $stable(rsp_result_offset) && $stable(rsp_status))
        else $error("stalled response changed");

    // failed responses carry no offset
    a_err_offset_zero: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && (rsp_status != ST_OK) |-> rsp_result_offset == '0)
        else $error("error response with nonzero offset");
endmodule

bind first_fit_block_allocator ffa_chk u_ffa_chk (
    .clk               (clk),
    .rst_n             (rst_n),
    .req_valid         (req.valid),
    .req_ready         (req.ready),
    .rsp_valid         (rsp.valid),
    .rsp_ready         (rsp.ready),
    .rsp_result_offset (rsp.result_offset),
    .rsp_status        (rsp.status)
);

// ----- tb/sv/first_fit_block_allocator_test.sv -----
module first_fit_block_allocator_test;
    import ffa_pkg::*;

    localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;
    localparam int unsigned WORD_BYTES      = 4;
    localparam int unsigned MIN_ARENA_BYTES = 8;
    localparam int unsigned HOLD_CYCLES     = 300;
    localparam int unsigned RUN_LIMIT       = 40_000_000;

    typedef struct packed {
        logic [OFF_W-1:0] offset;
        logic [ST_W-1:0]  status;
    } alloc_rsp_t;

    logic              clk;
    logic              rst_n;
    logic              cfg_we;
    logic [CFG_W-1:0]  cfg_wdata;

    ffa_req_if req_ch ();
    ffa_rsp_if rsp_ch ();

    first_fit_block_allocator u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req_ch),
        .rsp       (rsp_ch),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    // Header image of the arena: allocated mark, size in words, and whether
    // the entry has ever been written since reset.
    bit          heap_used   [FFA_ARENA_WORDS];
    int unsigned heap_words  [FFA_ARENA_WORDS];
    bit          hdr_written [FFA_ARENA_WORDS];
    int unsigned heap_span;

    alloc_rsp_t  rsp_due [$];
    alloc_rsp_t  head_rsp;
    int unsigned live_blocks [$];
    int unsigned last_freed = 0;

    bit idle_on  = 1'b1;
    bit hold_rsp = 1'b0;

    int err_cnt    = 0;
    int n_requests = 0;
    int n_granted  = 0;
    int n_oom      = 0;
    int n_rejected = 0;
    int n_arenas   = 0;

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    initial
    begin
        #(RUN_LIMIT);
        $display("RESULT: ERROR");
        $finish;
    end

    function automatic void load_arena(input logic [CFG_W-1:0] bytes);
        int unsigned eff;
        eff = 32'(bytes);
        if (eff < MIN_ARENA_BYTES)
            eff = MIN_ARENA_BYTES;
        if (eff > WORD_BYTES * FFA_ARENA_WORDS)
            eff = WORD_BYTES * FFA_ARENA_WORDS;
        heap_span      = eff / WORD_BYTES;
        heap_used[0]   = 1'b0;
        heap_words[0]  = heap_span - 1;
        hdr_written[0] = 1'b1;
    endfunction

    function automatic void reset_heap();
        for (int i = 0; i < FFA_ARENA_WORDS; i++)
        begin
            heap_used[i]   = 1'b0;
            heap_words[i]  = 0;
            hdr_written[i] = 1'b0;
        end
        load_arena(ARENA_BYTES_RST);
    endfunction

    // First-fit walk from header 0; splits the leftover off as a free block.
    function automatic bit find_first_fit(input int unsigned bytes,
                                          output int unsigned hdr);
        int unsigned need;
        int unsigned h;
        int unsigned w;
        int unsigned rest;
        need = (bytes + WORD_BYTES - 1) / WORD_BYTES;
        h    = 0;
        hdr  = 0;
        while (h < heap_span)
        begin
            w = heap_words[h];
            if (!heap_used[h] && w >= need && h + 1 < heap_span &&
                h + 1 + need <= heap_span)
            begin
                heap_used[h]  = 1'b1;
                heap_words[h] = need;
                rest          = h + 1 + need;
                if (w > need && rest < heap_span)
                begin
                    heap_used[rest]   = 1'b0;
                    heap_words[rest]  = w - need - 1;
                    hdr_written[rest] = 1'b1;
                end
                hdr = h;
                return 1'b1;
            end
            h += 1 + w;
        end
        return 1'b0;
    endfunction

    function automatic bit holds_block(input int unsigned off, output int unsigned hdr);
        hdr = 0;
        if (off == 0 || off - 1 >= heap_span)
            return 1'b0;
        if (!heap_used[off - 1])
            return 1'b0;
        hdr = off - 1;
        return 1'b1;
    endfunction

    function automatic alloc_rsp_t predict_request(input logic [KIND_W-1:0] kind,
                                                   input logic [SIZE_W-1:0] bytes,
                                                   input logic [OFF_W-1:0]  off);
        alloc_rsp_t  r;
        int unsigned hdr;
        int unsigned old;
        r.offset = '0;
        r.status = ST_OK;
        case (kind)
            KIND_ALLOC:
            begin
                if (find_first_fit(32'(bytes), hdr))
                    r.offset = OFF_W'(hdr + 1);
                else
                    r.status = ST_OOM;
            end
            KIND_FREE:
            begin
                if (holds_block(32'(off), old))
                    heap_used[old] = 1'b0;
                else
                    r.status = ST_NOT_ALLOC;
            end
            KIND_REALLOC:
            begin
                // old block stays held while the new one is searched for
                if (!holds_block(32'(off), old))
                    r.status = ST_NOT_ALLOC;
                else if (find_first_fit(32'(bytes), hdr))
                begin
                    heap_used[old] = 1'b0;
                    r.offset       = OFF_W'(hdr + 1);
                end
                else
                    r.status = ST_OOM;
            end
            default: ;
        endcase
        return r;
    endfunction

    function automatic void forget_block(input int unsigned off);
        for (int i = live_blocks.size() - 1; i >= 0; i--)
            if (live_blocks[i] == off)
                live_blocks.delete(i);
    endfunction

    function automatic int unsigned pick_size();
        int unsigned r;
        int unsigned span_bytes;
        r          = $urandom_range(0, 19);
        span_bytes = heap_span * WORD_BYTES;
        if (r < 10)
            return $urandom_range(0, span_bytes / 8);
        if (r < 16)
            return $urandom_range(0, span_bytes / 2);
        if (r < 18)
            return $urandom_range(0, span_bytes);
        if (r == 18)
            return (heap_span - 1) * WORD_BYTES - $urandom_range(0, 3);
        return $urandom_range(0, 32767);
    endfunction

    // Offset for a stray free or realloc; never points at a header slot that
    // has not been written since reset.
    function automatic int unsigned probe_offset();
        int unsigned off;
        for (int t = 0; t < 8; t++)
        begin
            if ($urandom_range(0, 1))
                off = $urandom_range(0, heap_span + 1) % FFA_ARENA_WORDS;
            else
                off = $urandom_range(0, FFA_ARENA_WORDS - 1);
            if (off == 0 || off - 1 >= heap_span || hdr_written[off - 1])
                return off;
        end
        return 0;
    endfunction

    task automatic issue_request(input logic [KIND_W-1:0] kind,
                                 input int unsigned bytes,
                                 input int unsigned off);
        alloc_rsp_t  outcome;
        int unsigned gap;
        @(negedge clk);
        if (idle_on && $urandom_range(0, 5) == 0)
        begin
            gap = $urandom_range(1, 14);
            req_ch.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        req_ch.valid        <= 1'b1;
        req_ch.kind         <= kind;
        req_ch.size_bytes   <= bytes[SIZE_W-1:0];
        req_ch.block_offset <= off[OFF_W-1:0];
        @(posedge clk);
        while (!req_ch.ready)
            @(posedge clk);
        outcome = predict_request(kind, bytes[SIZE_W-1:0], off[OFF_W-1:0]);
        rsp_due.push_back(outcome);
        n_requests++;
        case (outcome.status)
            ST_OK:   n_granted++;
            ST_OOM:  n_oom++;
            default: n_rejected++;
        endcase
        if (outcome.status == ST_OK)
        begin
            if (kind == KIND_FREE || kind == KIND_REALLOC)
            begin
                forget_block(32'(off[OFF_W-1:0]));
                last_freed = 32'(off[OFF_W-1:0]);
            end
            if (kind == KIND_ALLOC || kind == KIND_REALLOC)
                live_blocks.push_back(32'(outcome.offset));
        end
    endtask

    task automatic drain_responses();
        @(negedge clk);
        req_ch.valid <= 1'b0;
        while (rsp_due.size() != 0)
            @(negedge clk);
        repeat (8) @(negedge clk);
    endtask

    task automatic write_arena(input logic [CFG_W-1:0] bytes);
        drain_responses();
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= bytes;
        @(negedge clk);
        cfg_we    <= 1'b0;
        load_arena(bytes);
        live_blocks.delete();
        n_arenas++;
    endtask

    task automatic mixed_traffic(input int n);
        int unsigned r;
        int unsigned pick;
        for (int i = 0; i < n; i++)
        begin
            r = $urandom_range(0, 99);
            if (r < 45 || (live_blocks.size() == 0 && r < 87))
                issue_request(KIND_ALLOC, pick_size(), $urandom_range(0, 4095));
            else if (r < 72)
            begin
                pick = $urandom_range(0, live_blocks.size() - 1);
                issue_request(KIND_FREE, $urandom_range(0, 32767), live_blocks[pick]);
            end
            else if (r < 87)
            begin
                pick = $urandom_range(0, live_blocks.size() - 1);
                issue_request(KIND_REALLOC, pick_size(), live_blocks[pick]);
            end
            else if (r < 93)
                issue_request($urandom_range(0, 1) ? KIND_FREE : KIND_REALLOC,
                              pick_size(), probe_offset());
            else if (r < 96)
                issue_request(KIND_UNUSED, $urandom_range(0, 32767),
                              $urandom_range(0, 4095));
            else
                issue_request(KIND_FREE, 0, last_freed);
        end
    endtask

    // Arena left at its reset size: one block spanning it, exhaustion, double free.
    task automatic test_reset_arena();
        issue_request(KIND_ALLOC, 16380, 0);
        issue_request(KIND_ALLOC, 0, 0);
        issue_request(KIND_FREE, 0, 1);
        issue_request(KIND_FREE, 0, 1);
        issue_request(KIND_FREE, 0, 0);
        issue_request(KIND_UNUSED, 32767, 4095);
        issue_request(KIND_ALLOC, 16384, 0);
        issue_request(KIND_ALLOC, 32767, 0);
    endtask

    // Clamped sizes, block at the arena end, zero-word free blocks.
    task automatic test_arena_limits();
        write_arena(CFG_W'(0));
        issue_request(KIND_ALLOC, 0, 0);
        issue_request(KIND_ALLOC, 0, 0);
        write_arena(CFG_W'(32767));
        issue_request(KIND_ALLOC, 16380, 0);
        write_arena(CFG_W'(35));
        issue_request(KIND_ALLOC, 0, 0);
        issue_request(KIND_ALLOC, 0, 0);
        issue_request(KIND_FREE, 0, 1);
        issue_request(KIND_ALLOC, 4, 0);
        issue_request(KIND_ALLOC, 0, 0);
    endtask

    task automatic test_realloc_paths();
        write_arena(CFG_W'(64));
        issue_request(KIND_ALLOC, 8, 0);
        issue_request(KIND_REALLOC, 12, 1);
        issue_request(KIND_REALLOC, 4, 1);
        issue_request(KIND_REALLOC, 16384, 4);
        issue_request(KIND_FREE, 0, 4095);
    endtask

    // Headers left behind by the previous layout now sit inside the arena.
    task automatic test_stale_headers();
        write_arena(CFG_W'(67));
        issue_request(KIND_FREE, 0, 4);
        issue_request(KIND_FREE, 0, 4);
        issue_request(KIND_FREE, 0, 8);
    endtask

    task automatic test_backpressure();
        write_arena(CFG_W'(1024));
        hold_rsp = 1'b1;
        for (int i = 0; i < 8; i++)
            issue_request(KIND_ALLOC, pick_size(), 0);
    endtask

    task automatic test_random_arenas();
        int unsigned r;
        int unsigned bytes;
        for (int p = 0; p < 18; p++)
        begin
            r = $urandom_range(0, 9);
            if (r < 6)
                bytes = $urandom_range(8, 1024);
            else if (r < 7)
                bytes = $urandom_range(0, 7);
            else if (r < 8)
                bytes = 16384;
            else if (r < 9)
                bytes = $urandom_range(16385, 32767);
            else
                bytes = $urandom_range(1025, 16383);
            write_arena(bytes[CFG_W-1:0]);
            mixed_traffic(55);
        end
    endtask

    task automatic test_streaming();
        idle_on = 1'b0;
        write_arena(CFG_W'($urandom_range(256, 4096)));
        mixed_traffic(130);
    endtask

    // Response side: random stalls, plus one long hold-off on request.
    initial
    begin
        rsp_ch.ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (hold_rsp)
            begin
                rsp_ch.ready <= 1'b0;
                repeat (HOLD_CYCLES - 1) @(negedge clk);
                hold_rsp = 1'b0;
            end
            else if (idle_on && $urandom_range(0, 7) == 0)
            begin
                rsp_ch.ready <= 1'b0;
                repeat ($urandom_range(1, 14) - 1) @(negedge clk);
            end
            else
                rsp_ch.ready <= 1'b1;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && rsp_ch.valid && rsp_ch.ready)
        begin
            if (rsp_due.size() == 0)
            begin
                $error("response transaction with none pending: result_offset %0d status %0d",
                       rsp_ch.result_offset, rsp_ch.status);
                err_cnt++;
            end
            else
            begin
                head_rsp = rsp_due.pop_front();
                if (rsp_ch.result_offset !== head_rsp.offset)
                begin
                    $error("result_offset: expected %0d, got %0d",
                           head_rsp.offset, rsp_ch.result_offset);
                    err_cnt++;
                end
                if (rsp_ch.status !== head_rsp.status)
                begin
                    $error("status: expected %0d, got %0d", head_rsp.status, rsp_ch.status);
                    err_cnt++;
                end
            end
        end
    end

    initial
    begin
        rst_n               = 1'b0;
        cfg_we              = 1'b0;
        cfg_wdata           = '0;
        req_ch.valid        = 1'b0;
        req_ch.kind         = KIND_ALLOC;
        req_ch.size_bytes   = '0;
        req_ch.block_offset = '0;
        reset_heap();
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_reset_arena();
        test_arena_limits();
        test_realloc_paths();
        test_stale_headers();
        test_backpressure();
        test_random_arenas();
        test_streaming();

        drain_responses();
        repeat (100) @(posedge clk);
        $display("Checked %0d requests across %0d arena size writes plus the reset size:",
                 n_requests, n_arenas);
        $display("  %0d granted, %0d out of memory, %0d rejected as not allocated",
                 n_granted, n_oom, n_rejected);
        if (err_cnt == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
